// ===== design/scalar_to_color_map_macros.svh =====
// ---------------------------------------------------------------------------
// Scalar to colour map assertion macros
// Shared immediate-style wrappers for concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef SCALAR_TO_COLOR_MAP_MACROS_SVH
`define SCALAR_TO_COLOR_MAP_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define STC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define STC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/stc_pkg.sv =====
// ---------------------------------------------------------------------------
// Scalar to colour map package
// Shared constants, register codes and control types.
// ---------------------------------------------------------------------------
package stc_pkg;

    localparam int MAX_KEYS    = 16;
    localparam int KEY_IDX_W   = $clog2(MAX_KEYS);
    localparam int SAMPLE_BITS = 32;
    localparam int FRAC_BITS   = 16;
    localparam int RANGE_W     = 32;
    localparam int COUNT_W     = 5;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_LOW  = 3'd0,
        CFG_RANGE_HIGH = 3'd1,
        CFG_KEY_COUNT  = 3'd2,
        CFG_NAN_RED    = 3'd3,
        CFG_NAN_GREEN  = 3'd4,
        CFG_NAN_BLUE   = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic valid;
        logic nan;
        logic last;
    } t_px_ctl;

endpackage

// ===== design/stc_if.sv =====
// ---------------------------------------------------------------------------
// Scalar to colour map channel interfaces
// Pixel/key input, colour output and configuration write channels.
// ---------------------------------------------------------------------------
interface stc_in_if #(
    parameter int SAMPLE_BITS = stc_pkg::SAMPLE_BITS,
    parameter int FRAC_BITS   = stc_pkg::FRAC_BITS
);
    logic                             valid;
    logic                             ready;
    logic                             op;
    logic signed [SAMPLE_BITS-1:0]    pixel_value;
    logic                             pixel_is_nan;
    logic                             pixel_last;
    logic [stc_pkg::KEY_IDX_W-1:0]    key_index;
    logic [FRAC_BITS:0]               key_position;
    logic [FRAC_BITS:0]               key_red;
    logic [FRAC_BITS:0]               key_green;
    logic [FRAC_BITS:0]               key_blue;

    modport source (output valid, op, pixel_value, pixel_is_nan, pixel_last, key_index,
                    key_position, key_red, key_green, key_blue, input ready);
    modport sink   (input valid, op, pixel_value, pixel_is_nan, pixel_last, key_index,
                    key_position, key_red, key_green, key_blue, output ready);
endinterface

interface stc_out_if;
    logic                         valid;
    logic                         ready;
    logic [stc_pkg::BYTE_W-1:0]   red;
    logic [stc_pkg::BYTE_W-1:0]   green;
    logic [stc_pkg::BYTE_W-1:0]   blue;
    logic                         last_out;

    modport source (output valid, red, green, blue, last_out, input ready);
    modport sink   (input valid, red, green, blue, last_out, output ready);
endinterface

interface stc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [stc_pkg::CFG_IDX_W-1:0]    index;
    logic [stc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/stc_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports with registered read data.
// ---------------------------------------------------------------------------
module stc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = stc_pkg::MAX_KEYS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== design/stc_div.sv =====
// ---------------------------------------------------------------------------
// Pipelined fraction divider
// Restoring division of num/den (num < den), one quotient bit per stage.
// ---------------------------------------------------------------------------
module stc_div #(
    parameter int NW = 32,
    parameter int QB = 16,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [NW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QB-1:0] o_quot,
    output logic [SW-1:0] o_side
);

    localparam int RW = NW + 1;

    logic          r_v    [QB];
    logic [RW-1:0] r_rem  [QB];
    logic [NW-1:0] r_den  [QB];
    logic [QB-1:0] r_q    [QB];
    logic [SW-1:0] r_side [QB];

    logic [RW-1:0] w_rem_in [QB];
    logic [NW-1:0] w_den_in [QB];
    logic [QB-1:0] w_q_in   [QB];
    logic [RW-1:0] w_sh     [QB];
    logic          w_ge     [QB];
    logic [RW-1:0] n_rem    [QB];
    logic [QB-1:0] n_q      [QB];

    always_comb begin
        w_rem_in[0] = {1'b0, i_num};
        w_den_in[0] = i_den;
        w_q_in[0]   = '0;
        for (int i = 1; i < QB; i++) begin
            w_rem_in[i] = r_rem[i-1];
            w_den_in[i] = r_den[i-1];
            w_q_in[i]   = r_q[i-1];
        end
        for (int i = 0; i < QB; i++) begin
            // remainder stays below den, so its top bit is free for the shift
            w_sh[i]  = {w_rem_in[i][RW-2:0], 1'b0};
            w_ge[i]  = (w_sh[i] >= {1'b0, w_den_in[i]});
            n_rem[i] = w_ge[i] ? (w_sh[i] - {1'b0, w_den_in[i]}) : w_sh[i];
            n_q[i]   = {w_q_in[i][QB-2:0], w_ge[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QB; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int i = 1; i < QB; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_den[0]  <= i_den;
            for (int i = 1; i < QB; i++) begin
                r_side[i] <= r_side[i-1];
                r_den[i]  <= r_den[i-1];
            end
            for (int i = 0; i < QB; i++) begin
                r_rem[i] <= n_rem[i];
                r_q[i]   <= n_q[i];
            end
        end
    end

    assign o_valid = r_v[QB-1];
    assign o_quot  = r_q[QB-1];
    assign o_side  = r_side[QB-1];

endmodule

// ===== design/stc_lookup.sv =====
// ---------------------------------------------------------------------------
// Key table and segment search
// Applies key writes in stream order, finds the bracketing segment and reads
// both of its keys.
// ---------------------------------------------------------------------------
module stc_lookup #(
    parameter int FRAC_BITS = stc_pkg::FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  stc_pkg::t_px_ctl               i_ctl,
    input  logic                           i_op,
    input  logic [FRAC_BITS:0]             i_t,
    input  logic [stc_pkg::COUNT_W-1:0]    i_key_count,
    input  logic [stc_pkg::KEY_IDX_W-1:0]  i_key_idx,
    input  logic [FRAC_BITS:0]             i_key_pos,
    input  logic [FRAC_BITS:0]             i_key_red,
    input  logic [FRAC_BITS:0]             i_key_green,
    input  logic [FRAC_BITS:0]             i_key_blue,
    output stc_pkg::t_px_ctl               o_ctl,
    output logic [FRAC_BITS:0]             o_t,
    output logic [4*(FRAC_BITS+1)-1:0]     o_key_a,
    output logic [4*(FRAC_BITS+1)-1:0]     o_key_b
);

    localparam int KW = FRAC_BITS + 1;
    localparam int CW = stc_pkg::COUNT_W;
    localparam int IW = stc_pkg::KEY_IDX_W;
    localparam int NK = stc_pkg::MAX_KEYS;

    logic [KW-1:0]    r_pos [NK];
    stc_pkg::t_px_ctl r_ctl;
    logic [KW-1:0]    r_t;

    logic             w_wr;
    logic [CW-1:0]    w_kc;
    logic [IW-1:0]    w_ki;
    logic [IW-1:0]    w_kj;

    assign w_wr = i_en && i_ctl.valid && i_op;

    // saturate the key count to the range 2 to MAX_KEYS
    always_comb begin
        priority if (i_key_count < CW'(2)) begin
            w_kc = CW'(2);
        end else if (i_key_count > CW'(NK)) begin
            w_kc = CW'(NK);
        end else begin
            w_kc = i_key_count;
        end
    end

    // first key at or above t closes the segment; default to the last one
    always_comb begin
        w_ki = IW'(w_kc - CW'(2));
        for (int k = NK - 1; k >= 1; k--) begin
            if ((CW'(k) < w_kc) && (i_t <= r_pos[k])) begin
                w_ki = IW'(k - 1);
            end
        end
    end

    assign w_kj = w_ki + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_pos[i_key_idx] <= i_key_pos;
        end
    end

    stc_ram #(
        .WIDTH (4 * KW),
        .DEPTH (NK)
    ) u_keys (
        .i_clk     (i_clk),
        .i_we      (w_wr),
        .i_waddr   (i_key_idx),
        .i_wdata   ({i_key_pos, i_key_red, i_key_green, i_key_blue}),
        .i_re      (i_en),
        .i_raddr_a (w_ki),
        .i_raddr_b (w_kj),
        .o_rdata_a (o_key_a),
        .o_rdata_b (o_key_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid && !i_op;
            r_ctl.nan   <= i_ctl.nan;
            r_ctl.last  <= i_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t <= i_t;
        end
    end

    assign o_ctl = r_ctl;
    assign o_t   = r_t;

endmodule

// ===== design/stc_blend.sv =====
// ---------------------------------------------------------------------------
// Colour blend
// Interpolates the three channels, scales to bytes and selects the NaN colour.
// ---------------------------------------------------------------------------
module stc_blend #(
    parameter int FRAC_BITS = stc_pkg::FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  stc_pkg::t_px_ctl               i_ctl,
    input  logic [FRAC_BITS:0]             i_lam,
    input  logic [3*(FRAC_BITS+1)-1:0]     i_col_a,
    input  logic [3*(FRAC_BITS+1)-1:0]     i_col_b,
    input  logic [3*stc_pkg::BYTE_W-1:0]   i_nan_rgb,
    output stc_pkg::t_px_ctl               o_ctl,
    output logic [stc_pkg::BYTE_W-1:0]     o_red,
    output logic [stc_pkg::BYTE_W-1:0]     o_green,
    output logic [stc_pkg::BYTE_W-1:0]     o_blue
);

    localparam int KW = FRAC_BITS + 1;
    localparam int PW = 2 * KW;
    localparam int XW = PW + 8;
    localparam int BW = XW - 2 * FRAC_BITS;
    localparam int YW = stc_pkg::BYTE_W;
    localparam logic [KW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    stc_pkg::t_px_ctl r_p_ctl;
    stc_pkg::t_px_ctl r_s_ctl;
    stc_pkg::t_px_ctl r_o_ctl;
    logic [PW-1:0]    r_pa  [3];
    logic [PW-1:0]    r_pb  [3];
    logic [PW-1:0]    r_sum [3];
    logic [YW-1:0]    r_byte [3];

    logic [KW-1:0]    w_inv;
    logic [KW-1:0]    w_ca [3];
    logic [KW-1:0]    w_cb [3];
    logic [YW-1:0]    w_nan [3];
    logic [XW-1:0]    w_x  [3];
    logic [BW-1:0]    w_b  [3];
    logic [YW-1:0]    n_byte [3];

    assign w_inv = ONE - i_lam;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_ca[c]  = i_col_a[(3-c)*KW-1 -: KW];
            w_cb[c]  = i_col_b[(3-c)*KW-1 -: KW];
            w_nan[c] = i_nan_rgb[(3-c)*YW-1 -: YW];
            // 255 * mix, then drop the fraction
            w_x[c]   = {r_sum[c], 8'b0} - XW'(r_sum[c]);
            w_b[c]   = w_x[c][XW-1:2*FRAC_BITS];
            if (r_s_ctl.nan) begin
                n_byte[c] = w_nan[c];
            end else if (w_b[c] > BW'(255)) begin
                n_byte[c] = {YW{1'b1}};
            end else begin
                n_byte[c] = w_b[c][YW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl <= '0;
            r_s_ctl <= '0;
            r_o_ctl <= '0;
        end else if (i_en) begin
            r_p_ctl <= i_ctl;
            r_s_ctl <= r_p_ctl;
            r_o_ctl <= r_s_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_pa[c]   <= PW'(w_inv) * PW'(w_ca[c]);
                r_pb[c]   <= PW'(i_lam) * PW'(w_cb[c]);
                r_sum[c]  <= r_pa[c] + r_pb[c];
                r_byte[c] <= n_byte[c];
            end
        end
    end

    assign o_ctl   = r_o_ctl;
    assign o_red   = r_byte[0];
    assign o_green = r_byte[1];
    assign o_blue  = r_byte[2];

endmodule

// ===== design/scalar_to_color_map.sv =====
// ---------------------------------------------------------------------------
// Scalar to colour map
// Piecewise-linear colour map lookup for a stream of scalar pixels.
// ---------------------------------------------------------------------------
//  port    dir  handshake     carries
//  i_in    in   valid/ready   op, pixel sample and flags, or one key write
//  o_out   out  valid/ready   red, green, blue bytes and last_out
//  i_cfg   in   valid/ready   register index and write data (always ready)
//
//  One transaction enters per clock while o_out is not stalled; a pixel passes
//  through the two bit-per-stage dividers on its way to o_out.
//  Key writes take effect in stream order at the segment search stage and
//  leave no result.
//  Reset (i_rst_n low at a clock edge) clears all valid bits and resets the
//  config registers; the key table holds whatever it held until written.
//  A stall on o_out freezes every stage, and i_in.ready drops with it.
// ---------------------------------------------------------------------------
`include "scalar_to_color_map_macros.svh"

module scalar_to_color_map #(
    parameter int SAMPLE_BITS = stc_pkg::SAMPLE_BITS,
    parameter int FRAC_BITS   = stc_pkg::FRAC_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    stc_in_if.sink       i_in,
    stc_out_if.source    o_out,
    stc_cfg_if.sink      i_cfg
);

    localparam int KW  = FRAC_BITS + 1;
    localparam int NW  = stc_pkg::RANGE_W;
    localparam int DW  = NW + 1;
    localparam int IW  = stc_pkg::KEY_IDX_W;
    localparam int CW  = stc_pkg::COUNT_W;
    localparam int YW  = stc_pkg::BYTE_W;
    localparam int SW0 = 3 + IW + 4 * KW;
    localparam int SW1 = SW0 + 1 + KW;
    localparam int SW2 = 2 + 6 * KW + 1 + KW;
    localparam logic [KW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [NW-1:0] r_range_low;
    logic [NW-1:0] r_range_high;
    logic [CW-1:0] r_key_count;
    logic [YW-1:0] r_nan_red;
    logic [YW-1:0] r_nan_green;
    logic [YW-1:0] r_nan_blue;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= '0;
            r_range_high <= NW'(65535);
            r_key_count  <= CW'(2);
            r_nan_red    <= '0;
            r_nan_green  <= '0;
            r_nan_blue   <= '0;
        end else if (i_cfg.valid) begin
            unique case (stc_pkg::t_cfg_reg'(i_cfg.index))
                stc_pkg::CFG_RANGE_LOW:  r_range_low  <= i_cfg.data[NW-1:0];
                stc_pkg::CFG_RANGE_HIGH: r_range_high <= i_cfg.data[NW-1:0];
                stc_pkg::CFG_KEY_COUNT:  r_key_count  <= i_cfg.data[CW-1:0];
                stc_pkg::CFG_NAN_RED:    r_nan_red    <= i_cfg.data[YW-1:0];
                stc_pkg::CFG_NAN_GREEN:  r_nan_green  <= i_cfg.data[YW-1:0];
                stc_pkg::CFG_NAN_BLUE:   r_nan_blue   <= i_cfg.data[YW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Global advance: every stage moves when the output register is free
    // ---------------------------------------------------------------------
    logic             w_en;
    stc_pkg::t_px_ctl w_bl_ctl;

    assign w_en       = !w_bl_ctl.valid || o_out.ready;
    assign i_in.ready = w_en;

    // ---------------------------------------------------------------------
    // Stage 1: offsets of the sample and of the range top from range_low
    // ---------------------------------------------------------------------
    logic                 r1_v;
    logic [SW0-1:0]       r1_side;
    logic signed [DW-1:0] r1_num;
    logic signed [DW-1:0] r1_den;
    logic [DW-1:0]        w_sample;
    logic [DW-1:0]        w_low;
    logic [DW-1:0]        w_high;

    assign w_sample = {{(DW-SAMPLE_BITS){i_in.pixel_value[SAMPLE_BITS-1]}}, i_in.pixel_value};
    assign w_low    = {r_range_low[NW-1], r_range_low};
    assign w_high   = {r_range_high[NW-1], r_range_high};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_side <= {i_in.op, i_in.pixel_is_nan, i_in.pixel_last, i_in.key_index,
                        i_in.key_position, i_in.key_red, i_in.key_green, i_in.key_blue};
            r1_num  <= w_sample - w_low;
            r1_den  <= w_high - w_low;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: fold the sign into the denominator and settle the clamp cases
    // ---------------------------------------------------------------------
    logic                 r2_v;
    logic [SW0-1:0]       r2_side;
    logic                 r2_direct;
    logic [KW-1:0]        r2_dval;
    logic [NW-1:0]        r2_n;
    logic [NW-1:0]        r2_d;
    logic signed [DW-1:0] w_n1;
    logic signed [DW-1:0] w_d1;
    logic                 n2_direct;
    logic [KW-1:0]        n2_dval;

    assign w_n1 = r1_den[DW-1] ? -r1_num : r1_num;
    assign w_d1 = r1_den[DW-1] ? -r1_den : r1_den;

    always_comb begin
        n2_direct = 1'b1;
        n2_dval   = '0;
        // an empty range splits at range_low
        priority if (r1_den == '0) begin
            n2_dval = r1_num[DW-1] ? '0 : ONE;
        end else if (w_n1 <= 0) begin
            n2_dval = '0;
        end else if (w_n1 >= w_d1) begin
            n2_dval = ONE;
        end else begin
            n2_direct = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_side   <= r1_side;
            r2_direct <= n2_direct;
            r2_dval   <= n2_dval;
            r2_n      <= w_n1[NW-1:0];
            r2_d      <= w_d1[NW-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Normalising divider: t = num / den in Q0.FRAC_BITS
    // ---------------------------------------------------------------------
    logic                 w_d1v;
    logic [FRAC_BITS-1:0] w_d1q;
    logic [SW1-1:0]       w_d1s;
    logic                 w_t_op;
    logic                 w_t_nan;
    logic                 w_t_last;
    logic [IW-1:0]        w_t_idx;
    logic [KW-1:0]        w_t_pos;
    logic [KW-1:0]        w_t_red;
    logic [KW-1:0]        w_t_green;
    logic [KW-1:0]        w_t_blue;
    logic                 w_t_direct;
    logic [KW-1:0]        w_t_dval;
    logic [KW-1:0]        w_t;
    stc_pkg::t_px_ctl     w_lk_in;

    stc_div #(
        .NW (NW),
        .QB (FRAC_BITS),
        .SW (SW1)
    ) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_v),
        .i_num   (r2_n),
        .i_den   (r2_d),
        .i_side  ({r2_side, r2_direct, r2_dval}),
        .o_valid (w_d1v),
        .o_quot  (w_d1q),
        .o_side  (w_d1s)
    );

    assign {w_t_op, w_t_nan, w_t_last, w_t_idx, w_t_pos, w_t_red, w_t_green, w_t_blue,
            w_t_direct, w_t_dval} = w_d1s;
    assign w_t = w_t_direct ? w_t_dval : {1'b0, w_d1q};

    assign w_lk_in.valid = w_d1v;
    assign w_lk_in.nan   = w_t_nan;
    assign w_lk_in.last  = w_t_last;

    // ---------------------------------------------------------------------
    // Segment search and key table
    // ---------------------------------------------------------------------
    stc_pkg::t_px_ctl w_lk_ctl;
    logic [KW-1:0]    w_lk_t;
    logic [4*KW-1:0]  w_key_a;
    logic [4*KW-1:0]  w_key_b;

    stc_lookup #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lookup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_ctl       (w_lk_in),
        .i_op        (w_t_op),
        .i_t         (w_t),
        .i_key_count (r_key_count),
        .i_key_idx   (w_t_idx),
        .i_key_pos   (w_t_pos),
        .i_key_red   (w_t_red),
        .i_key_green (w_t_green),
        .i_key_blue  (w_t_blue),
        .o_ctl       (w_lk_ctl),
        .o_t         (w_lk_t),
        .o_key_a     (w_key_a),
        .o_key_b     (w_key_b)
    );

    // ---------------------------------------------------------------------
    // Stage 3: offset within the segment; zero-width segments take lambda 0
    // ---------------------------------------------------------------------
    stc_pkg::t_px_ctl     r3_ctl;
    logic                 r3_direct;
    logic [KW-1:0]        r3_dval;
    logic [KW-1:0]        r3_n;
    logic [KW-1:0]        r3_d;
    logic [3*KW-1:0]      r3_col_a;
    logic [3*KW-1:0]      r3_col_b;
    logic [KW-1:0]        w_pa;
    logic [KW-1:0]        w_pb;
    logic signed [KW:0]   w_n2raw;
    logic signed [KW:0]   w_d2raw;
    logic signed [KW:0]   w_n2;
    logic signed [KW:0]   w_d2;
    logic                 n3_direct;
    logic [KW-1:0]        n3_dval;

    assign w_pa    = w_key_a[4*KW-1 -: KW];
    assign w_pb    = w_key_b[4*KW-1 -: KW];
    assign w_n2raw = {1'b0, w_lk_t} - {1'b0, w_pa};
    assign w_d2raw = {1'b0, w_pb} - {1'b0, w_pa};
    assign w_n2    = w_d2raw[KW] ? -w_n2raw : w_n2raw;
    assign w_d2    = w_d2raw[KW] ? -w_d2raw : w_d2raw;

    always_comb begin
        n3_direct = 1'b1;
        n3_dval   = '0;
        priority if (w_d2raw == '0) begin
            n3_dval = '0;
        end else if (w_n2 <= 0) begin
            n3_dval = '0;
        end else if (w_n2 >= w_d2) begin
            n3_dval = ONE;
        end else begin
            n3_direct = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else if (w_en) begin
            r3_ctl <= w_lk_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_direct <= n3_direct;
            r3_dval   <= n3_dval;
            r3_n      <= w_n2[KW-1:0];
            r3_d      <= w_d2[KW-1:0];
            r3_col_a  <= w_key_a[3*KW-1:0];
            r3_col_b  <= w_key_b[3*KW-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Lambda divider
    // ---------------------------------------------------------------------
    logic                 w_d2v;
    logic [FRAC_BITS-1:0] w_d2q;
    logic [SW2-1:0]       w_d2s;
    logic                 w_l_nan;
    logic                 w_l_last;
    logic [3*KW-1:0]      w_l_col_a;
    logic [3*KW-1:0]      w_l_col_b;
    logic                 w_l_direct;
    logic [KW-1:0]        w_l_dval;
    logic [KW-1:0]        w_lam;
    stc_pkg::t_px_ctl     w_bl_in;

    stc_div #(
        .NW (KW),
        .QB (FRAC_BITS),
        .SW (SW2)
    ) u_div_lam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_ctl.valid),
        .i_num   (r3_n),
        .i_den   (r3_d),
        .i_side  ({r3_ctl.nan, r3_ctl.last, r3_col_a, r3_col_b, r3_direct, r3_dval}),
        .o_valid (w_d2v),
        .o_quot  (w_d2q),
        .o_side  (w_d2s)
    );

    assign {w_l_nan, w_l_last, w_l_col_a, w_l_col_b, w_l_direct, w_l_dval} = w_d2s;
    assign w_lam = w_l_direct ? w_l_dval : {1'b0, w_d2q};

    assign w_bl_in.valid = w_d2v;
    assign w_bl_in.nan   = w_l_nan;
    assign w_bl_in.last  = w_l_last;

    // ---------------------------------------------------------------------
    // Blend, scale and output register
    // ---------------------------------------------------------------------
    stc_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_ctl     (w_bl_in),
        .i_lam     (w_lam),
        .i_col_a   (w_l_col_a),
        .i_col_b   (w_l_col_b),
        .i_nan_rgb ({r_nan_red, r_nan_green, r_nan_blue}),
        .o_ctl     (w_bl_ctl),
        .o_red     (o_out.red),
        .o_green   (o_out.green),
        .o_blue    (o_out.blue)
    );

    assign o_out.valid    = w_bl_ctl.valid;
    assign o_out.last_out = w_bl_ctl.last;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `STC_ASSERT_IMP(a_t_div_in_range, i_clk, i_rst_n, r2_v && !r2_direct, r2_n < r2_d, "t divider operands out of range")
    `STC_ASSERT_IMP(a_lam_div_in_range, i_clk, i_rst_n, r3_ctl.valid && !r3_direct, r3_n < r3_d, "lambda divider operands out of range")
    `STC_ASSERT_NXT(a_stall_freezes, i_clk, i_rst_n, !w_en, $stable(w_d1v) && $stable(w_lk_ctl.valid) && $stable(r3_ctl.valid), "pipeline moved during a stall")

endmodule
